[src/f2p_pkg.sv]
// Shared types and constants for the float-to-PCM sample encoder.
// No dependencies; used by every module under src.
package f2p_pkg;

  // Output sample formats, as held in the format register
  typedef enum logic [2:0] {
    FMT_INT16LE   = 3'd0,
    FMT_INT16BE   = 3'd1,
    FMT_INT24LE   = 3'd2,
    FMT_INT24BE   = 3'd3,
    FMT_INT32LE   = 3'd4,
    FMT_INT32BE   = 3'd5,
    FMT_FLOAT32LE = 3'd6,
    FMT_FLOAT32BE = 3'd7
  } fmt_e;

  // Full-scale values 2^(N-1)-1
  localparam logic [30:0] MAX_INT16 = 31'h0000_7fff;
  localparam logic [30:0] MAX_INT24 = 31'h007f_ffff;
  localparam logic [30:0] MAX_INT32 = 31'h7fff_ffff;

  // Right shift that takes the scaled mantissa to the integer point
  localparam logic [7:0] SHIFT_BIAS   = 8'd150;
  localparam logic [7:0] SHIFT_SUBNRM = 8'd149;
  localparam logic [7:0] EXP_ONE      = 8'd127;

  // Fields common to every stage
  typedef struct packed {
    fmt_e        fmt;
    logic        last;
    logic [31:0] bits;   // raw sample, kept for float pass-through
    logic        sign;
    logic        nan;
    logic        big;    // |x| >= 1 or infinite: clamps to full scale
    logic [7:0]  shamt;
    logic [30:0] maxv;
  } f2p_ctl_t;

  typedef struct packed {
    f2p_ctl_t    ctl;
    logic [23:0] mant;
  } f2p_dec_t;

  typedef struct packed {
    f2p_ctl_t    ctl;
    logic [54:0] prod;
  } f2p_mul_t;

  typedef struct packed {
    f2p_ctl_t    ctl;
    logic [31:0] mag;
  } f2p_rnd_t;

endpackage

[src/float_to_pcm_sample_encoder.sv]
// Float32 to PCM sample encoder, top level. Depends on f2p_pkg and all f2p_* stages.
// Five register stages (decode, multiply, 53-bit round, integer round, pack), the first
// loaded at the accept edge. Throughput one item per cycle unless the output stalls;
// each stage moves on when the next can take it, so a stall at the output backs up
// without loss or repeat.
// Reset clears all stage valid bits and sets the format register to int16LE.
module float_to_pcm_sample_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,        // sample_format
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,     // [31:0] float_sample_bits
  input  logic        s_axis_tlast_i,     // last_sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,     // [31:0] pcm_word
  output logic        m_axis_tlast_o      // last_out
);

  f2p_pkg::fmt_e     fmt_q;
  f2p_pkg::fmt_e     out_fmt;
  f2p_pkg::f2p_dec_t dec_data;
  f2p_pkg::f2p_mul_t mul_data;
  f2p_pkg::f2p_rnd_t rnd_data;
  logic dec_valid, dec_ready, mul_valid, mul_ready, rnd_valid, rnd_ready;

  // Format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= f2p_pkg::FMT_INT16LE;
    end else if (cfg_we_i) begin
      fmt_q <= f2p_pkg::fmt_e'(cfg_wdata_i);
    end
  end

  f2p_decode u_decode (
    .clk_i, .rst_ni,
    .valid_i (s_axis_tvalid_i), .ready_o (s_axis_tready_o),
    .bits_i  (s_axis_tdata_i),  .last_i  (s_axis_tlast_i), .fmt_i (fmt_q),
    .valid_o (dec_valid), .ready_i (dec_ready), .data_o (dec_data)
  );

  f2p_mul u_mul (
    .clk_i, .rst_ni,
    .valid_i (dec_valid), .ready_o (dec_ready), .data_i (dec_data),
    .valid_o (mul_valid), .ready_i (mul_ready), .data_o (mul_data)
  );

  f2p_round u_round (
    .clk_i, .rst_ni,
    .valid_i (mul_valid), .ready_o (mul_ready), .data_i (mul_data),
    .valid_o (rnd_valid), .ready_i (rnd_ready), .data_o (rnd_data)
  );

  f2p_pack u_pack (
    .clk_i, .rst_ni,
    .valid_i (rnd_valid), .ready_o (rnd_ready), .data_i (rnd_data),
    .valid_o (m_axis_tvalid_o), .ready_i (m_axis_tready_i),
    .word_o  (m_axis_tdata_o),  .last_o (m_axis_tlast_o), .fmt_o (out_fmt)
  );

  // Input back-pressure only comes from a full pipe behind a stalled output
  a_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output stall");

  // 16-bit formats leave the upper bytes zero
  a_int16_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_fmt == f2p_pkg::FMT_INT16LE ||
                         out_fmt == f2p_pkg::FMT_INT16BE))
    |-> (m_axis_tdata_o[31:16] == 16'd0))
    else $error("int16 word has nonzero upper bytes");

  // 24-bit formats leave the top byte zero
  a_int24_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_fmt == f2p_pkg::FMT_INT24LE ||
                         out_fmt == f2p_pkg::FMT_INT24BE))
    |-> (m_axis_tdata_o[31:24] == 8'd0))
    else $error("int24 word has nonzero top byte");

endmodule

[src/f2p_decode.sv]
// Input stage: splits the float sample into mantissa, shift and flags.
// Depends on f2p_pkg.
module f2p_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [31:0]           bits_i,
  input  logic                  last_i,
  input  f2p_pkg::fmt_e         fmt_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output f2p_pkg::f2p_dec_t     data_o
);

  logic              valid_q;
  f2p_pkg::f2p_dec_t data_d, data_q;
  logic [7:0]        expo;
  logic [22:0]       frac;

  assign ready_o = !valid_q || ready_i;
  assign expo    = bits_i[30:23];
  assign frac    = bits_i[22:0];

  // Field decode and full-scale select
  always_comb begin
    data_d.ctl.fmt  = fmt_i;
    data_d.ctl.last = last_i;
    data_d.ctl.bits = bits_i;
    data_d.ctl.sign = bits_i[31];
    data_d.ctl.nan  = (expo == 8'hff) && (frac != 23'd0);
    data_d.ctl.big  = (expo >= f2p_pkg::EXP_ONE);
    if (expo == 8'd0) begin
      data_d.mant      = {1'b0, frac};
      data_d.ctl.shamt = f2p_pkg::SHIFT_SUBNRM;
    end else begin
      data_d.mant      = {1'b1, frac};
      data_d.ctl.shamt = f2p_pkg::SHIFT_BIAS - expo;
    end
    unique case (fmt_i)
      f2p_pkg::FMT_INT16LE, f2p_pkg::FMT_INT16BE: data_d.ctl.maxv = f2p_pkg::MAX_INT16;
      f2p_pkg::FMT_INT24LE, f2p_pkg::FMT_INT24BE: data_d.ctl.maxv = f2p_pkg::MAX_INT24;
      default:                                    data_d.ctl.maxv = f2p_pkg::MAX_INT32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/f2p_mul.sv]
// Multiply stage: mantissa times full-scale value, exact 55-bit product.
// Depends on f2p_pkg.
module f2p_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  f2p_pkg::f2p_dec_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output f2p_pkg::f2p_mul_t data_o
);

  logic              valid_q;
  f2p_pkg::f2p_mul_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // 24 x 31 unsigned product
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q.ctl  <= data_i.ctl;
      data_q.prod <= 55'(data_i.mant) * 55'(data_i.ctl.maxv);
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/f2p_round.sv]
// Two rounding stages: product to 53 significant bits (double precision),
// then shift to the integer point with round half to even. Depends on f2p_pkg.
module f2p_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  f2p_pkg::f2p_mul_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output f2p_pkg::f2p_rnd_t data_o
);

  // Stage A: 53-bit rounding
  logic              va_q;
  logic              ready_a;
  f2p_pkg::f2p_ctl_t ctl_a_q;
  logic [55:0]       p_a_d, p_a_q;
  logic [53:0]       keep2;
  logic [54:0]       keep1;

  // Stage B: integer rounding
  logic              vb_q;
  logic              ready_b;
  f2p_pkg::f2p_rnd_t data_b_d, data_b_q;
  logic [63:0]       x;
  logic [63:0]       q;
  logic [63:0]       r;
  logic [6:0]        lsh;
  logic              rnd_up;

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  // Drop one or two low bits when the product exceeds 53 bits
  always_comb begin
    keep2 = {1'b0, data_i.prod[54:2]} + 54'(data_i.prod[1] &
            (data_i.prod[0] | data_i.prod[2]));
    keep1 = {1'b0, data_i.prod[54:1]} + 55'(data_i.prod[0] & data_i.prod[1]);
    if (data_i.prod[54]) begin
      p_a_d = {keep2, 2'b00};
    end else if (data_i.prod[53]) begin
      p_a_d = {keep1, 1'b0};
    end else begin
      p_a_d = {1'b0, data_i.prod};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ready_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      ctl_a_q <= data_i.ctl;
      p_a_q   <= p_a_d;
    end
  end

  // Shift right to the integer point, guard and sticky from the shifted-out bits
  always_comb begin
    x      = {8'd0, p_a_q};
    lsh    = 7'd64 - {1'b0, ctl_a_q.shamt[5:0]};
    q      = x >> ctl_a_q.shamt[5:0];
    r      = x << lsh;
    rnd_up = r[63] & ((|r[62:0]) | q[0]);
    data_b_d.ctl = ctl_a_q;
    if (ctl_a_q.shamt >= 8'd64) begin
      data_b_d.mag = 32'd0;
    end else begin
      data_b_d.mag = q[31:0] + 32'(rnd_up);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ready_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      data_b_q <= data_b_d;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = data_b_q;

endmodule

[src/f2p_pack.sv]
// Output stage: clamp, sign, byte ordering and the output register.
// Depends on f2p_pkg.
module f2p_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  f2p_pkg::f2p_rnd_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [31:0]       word_o,
  output logic              last_o,
  output f2p_pkg::fmt_e     fmt_o
);

  logic          valid_q;
  logic [31:0]   word_d, word_q;
  logic          last_q;
  f2p_pkg::fmt_e fmt_q;
  logic [31:0]   mag;
  logic [31:0]   val;

  assign ready_o = !valid_q || ready_i;

  // Clamp, apply sign, order bytes
  always_comb begin
    if (data_i.ctl.nan) begin
      mag = 32'd0;
    end else if (data_i.ctl.big) begin
      mag = {1'b0, data_i.ctl.maxv};
    end else begin
      mag = data_i.mag;
    end
    val = data_i.ctl.sign ? (32'd0 - mag) : mag;
    unique case (data_i.ctl.fmt)
      f2p_pkg::FMT_INT16LE:   word_d = {16'd0, val[15:0]};
      f2p_pkg::FMT_INT16BE:   word_d = {16'd0, val[7:0], val[15:8]};
      f2p_pkg::FMT_INT24LE:   word_d = {8'd0, val[23:0]};
      f2p_pkg::FMT_INT24BE:   word_d = {8'd0, val[7:0], val[15:8], val[23:16]};
      f2p_pkg::FMT_INT32LE:   word_d = val;
      f2p_pkg::FMT_INT32BE:   word_d = {val[7:0], val[15:8], val[23:16], val[31:24]};
      f2p_pkg::FMT_FLOAT32LE: word_d = data_i.ctl.bits;
      default: word_d = {data_i.ctl.bits[7:0], data_i.ctl.bits[15:8],
                         data_i.ctl.bits[23:16], data_i.ctl.bits[31:24]};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
      last_q <= data_i.ctl.last;
      fmt_q  <= data_i.ctl.fmt;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign last_o  = last_q;
  assign fmt_o   = fmt_q;

endmodule

[tb/tb_float_to_pcm_sample_encoder.sv]
// Self-checking testbench for float_to_pcm_sample_encoder.
// Depends on f2p_pkg for the format codes; the block's expected PCM words are
// predicted with real arithmetic and compared in order against the output stream.
module tb_float_to_pcm_sample_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected PCM words and the format they are encoded in
  class pcm_scoreboard;
    f2p_pkg::fmt_e fmt;
    logic [32:0]   pending_q[$];   // {last, pcm_word}
    int            errors;

    function new();
      fmt = f2p_pkg::FMT_INT16LE;
      errors = 0;
    endfunction

    function real pow2(int n);
      real r;
      r = 1.0;
      if (n >= 0) begin
        repeat (n) r = r * 2.0;
      end else begin
        repeat (-n) r = r / 2.0;
      end
      return r;
    endfunction

    // Scale by full scale, clamp, round half to even
    function logic [31:0] scale_to_int(logic [31:0] bits, real maxv);
      real    mag, v, frac;
      integer t;
      if (bits[30:23] == 8'hff && bits[22:0] != 0) return 32'd0;
      if (bits[30:23] == 8'hff) mag = 1.0e300;
      else if (bits[30:23] == 0) mag = real'(bits[22:0]) * pow2(-149);
      else mag = real'({1'b1, bits[22:0]}) * pow2(int'(bits[30:23]) - 150);
      v = maxv * (bits[31] ? -mag : mag);
      if (v < -maxv) v = -maxv;
      if (v > maxv) v = maxv;
      t = $rtoi(v);
      frac = v - real'(t);
      if (frac > 0.5 || (frac == 0.5 && t[0])) t = t + 1;
      else if (frac < -0.5 || (frac == -0.5 && t[0])) t = t - 1;
      return t;
    endfunction

    function logic [31:0] bswap(logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function void note_sample(logic [31:0] bits, logic last);
      logic [31:0] u, word;
      case (fmt)
        f2p_pkg::FMT_INT16LE, f2p_pkg::FMT_INT16BE: u = scale_to_int(bits, 32767.0);
        f2p_pkg::FMT_INT24LE, f2p_pkg::FMT_INT24BE: u = scale_to_int(bits, 8388607.0);
        f2p_pkg::FMT_INT32LE, f2p_pkg::FMT_INT32BE: u = scale_to_int(bits, 2147483647.0);
        default: u = bits;
      endcase
      case (fmt)
        f2p_pkg::FMT_INT16LE: word = {16'd0, u[15:0]};
        f2p_pkg::FMT_INT16BE: word = {16'd0, u[7:0], u[15:8]};
        f2p_pkg::FMT_INT24LE: word = {8'd0, u[23:0]};
        f2p_pkg::FMT_INT24BE: word = {8'd0, u[7:0], u[15:8], u[23:16]};
        f2p_pkg::FMT_INT32BE, f2p_pkg::FMT_FLOAT32BE: word = bswap(u);
        default:              word = u;
      endcase
      pending_q.push_back({last, word});
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [31:0] word, logic last);
      logic [32:0] exp_item;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word %h", word));
        return;
      end
      exp_item = pending_q.pop_front();
      if (word !== exp_item[31:0])
        report($sformatf("fmt %s word %h, want %h", fmt.name(), word, exp_item[31:0]));
      if (last !== exp_item[32])
        report($sformatf("tlast %b, want %b", last, exp_item[32]));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  pcm_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 0;
  bit rx_hold = 0;

  float_to_pcm_sample_encoder dut (.*);

  always #2 clk_i = ~clk_i;

  // Output side: stall at random, or hold off entirely during a long hold
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o, m_axis_tlast_o);
  end

  // Long receiver hold, counted in its own process
  initial begin
    wait (hold_req);
    @(negedge clk_i);
    rx_hold = 1;
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
    rx_hold = 0;
  end

  // Offer one sample; returns at a falling edge after it is taken
  task send_sample(logic [31:0] bits, logic last);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i = 0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1;
    s_axis_tdata_i = bits;
    s_axis_tlast_i = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(bits, last);
    @(negedge clk_i);
  endtask

  task drain();
    s_axis_tvalid_i = 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task write_format(f2p_pkg::fmt_e f);
    cfg_we_i = 1;
    cfg_wdata_i = f;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.fmt = f;
  endtask

  function logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
      2: return {1'($urandom), 8'($urandom_range(110, 126)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(126, 128)), 23'($urandom_range(0, 3))};
    endcase
  endfunction

  logic [31:0] corner[18] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000, 32'h7f80_0000,
    32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff, 32'h7f80_0001, 32'h0000_0001,
    32'h807f_ffff, 32'h7f7f_ffff, 32'h3f00_0000, 32'h3f7f_ffff, 32'hbf00_0000,
    32'h3f80_0001, 32'h3800_0000, 32'h3780_0000};

  f2p_pkg::fmt_e order[9] = '{
    f2p_pkg::FMT_INT16LE, f2p_pkg::FMT_FLOAT32BE, f2p_pkg::FMT_INT16BE,
    f2p_pkg::FMT_FLOAT32LE, f2p_pkg::FMT_INT24LE, f2p_pkg::FMT_INT32BE,
    f2p_pkg::FMT_INT24BE, f2p_pkg::FMT_INT32LE, f2p_pkg::FMT_INT16LE};

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    foreach (order[p]) begin
      // first phase runs on the reset format
      if (p != 0) write_format(order[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      if (p == 4) hold_req = 1;
      foreach (corner[i]) send_sample(corner[i], i % 5 == 4);
      repeat (45) send_sample(rand_sample(), 1'($urandom_range(7) == 0));
      drain();
    end
    if (sb.errors == 0) $display("tb_float_to_pcm_sample_encoder passed");
    else $display("tb_float_to_pcm_sample_encoder failed");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("tb_float_to_pcm_sample_encoder failed");
    $finish;
  end
endmodule
